@@ rtl/core/cbm_pkg.sv @@
// Shared constants, types and helpers for the clipped box mean filter.
`default_nettype none

package cbm_pkg;

    localparam int MAX_RADIUS  = 8;
    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 4096;

    // Pixel history depth: (2*MAX_RADIUS+1) rows of MAX_WIDTH pixels
    localparam int STORE_DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int PIX_W       = 24;

    localparam int RAD_W  = 4;
    localparam int WID_W  = 12;
    localparam int HGT_W  = 13;
    localparam int POS_W  = WID_W + HGT_W - 1;
    localparam int SPAN_W = $clog2(2 * MAX_RADIUS + 2);
    localparam int CNT_W  = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int SUM_W  = CNT_W + 8;
    localparam int STEP_W = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = HGT_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

    // Input command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ADDR,
        ST_READ,
        ST_DRAIN,
        ST_DIVIDE,
        ST_EMIT
    } t_state;

    // Add an offset to a store address and wrap around the store depth
    function automatic logic [STORE_AW-1:0] wrap_add(input logic [STORE_AW-1:0] a,
                                                     input logic [STORE_AW-1:0] b);
        logic [STORE_AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (STORE_AW+1)'(STORE_DEPTH)) begin
            s = s - (STORE_AW+1)'(STORE_DEPTH);
        end
        return s[STORE_AW-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/cbm_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
`default_nettype none

module cbm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

@@ rtl/core/clipped_box_mean_filter_rgb.sv @@
// Clipped box mean filter: one pixel history memory walked per output window.
//
// Pixels enter in raster order and are written to a history memory of
// 17 rows x 2048 pixels. An item that yields a result (a pixel once radius rows
// plus radius columns have arrived, or a flush after the frame is complete)
// passes through the setup, address, read, drain, divide and emit states; the
// read state walks N = rows x columns pixels of the clipped window (1..289):
// the single read port of the history memory supplies one pixel per cycle, and
// the mean comes from an 8-step shift-subtract divider. An item with no result
// stays in the idle state. Results wait in an output register, so a stalled
// consumer does not stop the next item from being accepted. Register writes are
// taken only between items; a pending write holds off the input channel. Writing
// the radius, width or height register restarts the frame. No clearing pass.
`default_nettype none

module clipped_box_mean_filter_rgb
    import cbm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input pixel channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_command,
    input  wire logic [7:0]            i_red_in,
    input  wire logic [7:0]            i_green_in,
    input  wire logic [7:0]            i_blue_in,
    // result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [7:0]                 o_red_mean,
    output logic [7:0]                 o_green_mean,
    output logic [7:0]                 o_blue_mean,
    output logic                       o_frame_end,
    // configuration channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [RAD_W-1:0]    r_radius;
    logic [WID_W-1:0]    r_width;
    logic [HGT_W-1:0]    r_height;

    logic [POS_W-1:0]    r_in_pos, r_out_pos;
    logic [STORE_AW-1:0] r_wr_addr, r_q_addr;
    logic [WID_W-1:0]    r_ox;
    logic [HGT_W-1:0]    r_oy;

    logic [WID_W-1:0]    r_wx;
    logic [HGT_W-1:0]    r_wy;
    logic [STORE_AW-1:0] r_wq;
    logic                r_last;

    logic [RAD_W-1:0]    r_dy_up, r_dx_l;
    logic [SPAN_W-1:0]   r_rows, r_cols, r_row, r_col;
    logic [CNT_W-1:0]    r_cnt;
    logic [STORE_AW-1:0] r_cur, r_row_addr;
    logic                r_pend;

    logic [SUM_W-1:0]    r_sum_r, r_sum_g, r_sum_b;
    logic [7:0]          r_q_r, r_q_g, r_q_b;
    logic [STEP_W-1:0]   r_step;

    logic [PIX_W-1:0]    rd_data;
    logic                in_acc, cfg_acc, out_take, out_load;
    logic [POS_W-1:0]    total, lag;
    logic                restart, emit;
    logic [POS_W-1:0]    eff_in, eff_out;
    logic [STORE_AW-1:0] eff_wr, eff_q;
    logic [WID_W-1:0]    eff_ox;
    logic [HGT_W-1:0]    eff_oy;
    logic                wr_en;
    logic                row_end, win_end;

    // Handshakes: register writes only while no item is in flight
    assign o_in_ready  = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign out_take    = o_out_valid && i_out_ready;
    assign out_load    = (r_state == ST_EMIT) && (!o_out_valid || i_out_ready);

    // Frame geometry
    assign total = POS_W'(r_width) * POS_W'(r_height);
    assign lag   = POS_W'(r_radius) * POS_W'(r_width) + POS_W'(r_radius);

    // Effective frame counters: a pixel after a complete frame starts a new one
    assign restart = (i_command == CMD_PIXEL) && (r_in_pos >= total);
    assign eff_in  = restart ? '0 : r_in_pos;
    assign eff_out = restart ? '0 : r_out_pos;
    assign eff_wr  = restart ? '0 : r_wr_addr;
    assign eff_q   = restart ? '0 : r_q_addr;
    assign eff_ox  = restart ? '0 : r_ox;
    assign eff_oy  = restart ? '0 : r_oy;

    always_comb begin
        if (i_command == CMD_PIXEL) begin
            emit = (eff_in >= lag) && (eff_out < total);
        end else begin
            emit = (r_in_pos >= total) && (r_out_pos < total);
        end
    end

    assign wr_en = in_acc && (i_command == CMD_PIXEL);

    // Pixel history memory
    cbm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (eff_wr),
        .i_wr_data ({i_red_in, i_green_in, i_blue_in}),
        .i_rd_addr (r_cur),
        .o_rd_data (rd_data)
    );

    // Window walk end conditions
    assign row_end = (r_col == r_cols - 1'b1);
    assign win_end = row_end && (r_row == r_rows - 1'b1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_acc && emit) n_state = ST_SETUP;
            ST_SETUP:  n_state = ST_ADDR;
            ST_ADDR:   n_state = ST_READ;
            ST_READ:   if (win_end) n_state = ST_DRAIN;
            ST_DRAIN:  n_state = ST_DIVIDE;
            ST_DIVIDE: if (r_step == '0) n_state = ST_EMIT;
            ST_EMIT:   if (out_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers and frame counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius  <= RAD_W'(1);
            r_width   <= WID_W'(640);
            r_height  <= HGT_W'(480);
            r_in_pos  <= '0;
            r_out_pos <= '0;
            r_wr_addr <= '0;
            r_q_addr  <= '0;
            r_ox      <= '0;
            r_oy      <= '0;
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                CFG_RADIUS: begin
                    if (i_cfg_data[RAD_W-1:0] == '0) r_radius <= RAD_W'(1);
                    else if (i_cfg_data[RAD_W-1:0] > RAD_W'(MAX_RADIUS))
                        r_radius <= RAD_W'(MAX_RADIUS);
                    else r_radius <= i_cfg_data[RAD_W-1:0];
                end
                CFG_WIDTH: begin
                    if (i_cfg_data[WID_W-1:0] == '0) r_width <= WID_W'(1);
                    else if (i_cfg_data[WID_W-1:0] > WID_W'(MAX_WIDTH))
                        r_width <= WID_W'(MAX_WIDTH);
                    else r_width <= i_cfg_data[WID_W-1:0];
                end
                CFG_HEIGHT: begin
                    if (i_cfg_data == '0) r_height <= HGT_W'(1);
                    else if (i_cfg_data > HGT_W'(MAX_HEIGHT))
                        r_height <= HGT_W'(MAX_HEIGHT);
                    else r_height <= i_cfg_data;
                end
                default: ;
            endcase
            if (i_cfg_index inside {CFG_RADIUS, CFG_WIDTH, CFG_HEIGHT}) begin
                r_in_pos  <= '0;
                r_out_pos <= '0;
                r_wr_addr <= '0;
                r_q_addr  <= '0;
                r_ox      <= '0;
                r_oy      <= '0;
            end
        end else if (in_acc) begin
            if (i_command == CMD_PIXEL) begin
                r_in_pos  <= eff_in + 1'b1;
                r_wr_addr <= wrap_add(eff_wr, STORE_AW'(1));
            end
            if (emit) begin
                r_out_pos <= eff_out + 1'b1;
                r_q_addr  <= wrap_add(eff_q, STORE_AW'(1));
                if (eff_ox == r_width - 1'b1) begin
                    r_ox <= '0;
                    r_oy <= eff_oy + 1'b1;
                end else begin
                    r_ox <= eff_ox + 1'b1;
                    r_oy <= eff_oy;
                end
            end else begin
                r_out_pos <= eff_out;
                r_q_addr  <= eff_q;
                r_ox      <= eff_ox;
                r_oy      <= eff_oy;
            end
        end
    end

    // Capture the output position and walk the clipped window
    always_ff @(posedge i_clk) begin
        logic [RAD_W-1:0]    dy_dn, dx_r;
        logic [HGT_W-1:0]    below;
        logic [WID_W-1:0]    right;
        logic [STORE_AW-1:0] off;
        below = r_height - 1'b1 - r_wy;
        right = r_width - 1'b1 - r_wx;
        dy_dn = (below > HGT_W'(r_radius)) ? r_radius : below[RAD_W-1:0];
        dx_r  = (right > WID_W'(r_radius)) ? r_radius : right[RAD_W-1:0];
        off   = STORE_AW'(r_dy_up) * STORE_AW'(r_width) + STORE_AW'(r_dx_l);
        if (in_acc && emit) begin
            r_wx   <= eff_ox;
            r_wy   <= eff_oy;
            r_wq   <= eff_q;
            r_last <= (eff_out == total - 1'b1);
        end
        unique case (r_state)
            ST_SETUP: begin
                r_dy_up <= (r_wy > HGT_W'(r_radius)) ? r_radius : r_wy[RAD_W-1:0];
                r_dx_l  <= (r_wx > WID_W'(r_radius)) ? r_radius : r_wx[RAD_W-1:0];
                r_rows  <= SPAN_W'(((r_wy > HGT_W'(r_radius)) ? r_radius : r_wy[RAD_W-1:0]))
                         + SPAN_W'(dy_dn) + 1'b1;
                r_cols  <= SPAN_W'(((r_wx > WID_W'(r_radius)) ? r_radius : r_wx[RAD_W-1:0]))
                         + SPAN_W'(dx_r) + 1'b1;
            end
            ST_ADDR: begin
                r_cnt      <= CNT_W'(r_rows) * CNT_W'(r_cols);
                r_cur      <= wrap_add(r_wq, STORE_AW'(STORE_DEPTH) - off);
                r_row_addr <= wrap_add(r_wq, STORE_AW'(STORE_DEPTH) - off);
                r_row      <= '0;
                r_col      <= '0;
            end
            ST_READ: begin
                if (row_end) begin
                    r_col      <= '0;
                    r_row      <= r_row + 1'b1;
                    r_row_addr <= wrap_add(r_row_addr, STORE_AW'(r_width));
                    r_cur      <= wrap_add(r_row_addr, STORE_AW'(r_width));
                end else begin
                    r_col <= r_col + 1'b1;
                    r_cur <= wrap_add(r_cur, STORE_AW'(1));
                end
            end
            default: ;
        endcase
    end

    // Accumulate the window, then divide by the pixel count one bit a cycle
    always_ff @(posedge i_clk) begin
        logic [SUM_W-1:0] dsub;
        dsub = SUM_W'(r_cnt) << r_step;
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= (r_state == ST_READ);
        end
        if (r_state == ST_ADDR) begin
            r_sum_r <= '0;
            r_sum_g <= '0;
            r_sum_b <= '0;
            r_step  <= STEP_W'(7);
        end else if (r_pend) begin
            r_sum_r <= r_sum_r + SUM_W'(rd_data[23:16]);
            r_sum_g <= r_sum_g + SUM_W'(rd_data[15:8]);
            r_sum_b <= r_sum_b + SUM_W'(rd_data[7:0]);
        end else if (r_state == ST_DIVIDE) begin
            r_step <= r_step - 1'b1;
            if (r_sum_r >= dsub) r_sum_r <= r_sum_r - dsub;
            if (r_sum_g >= dsub) r_sum_g <= r_sum_g - dsub;
            if (r_sum_b >= dsub) r_sum_b <= r_sum_b - dsub;
            r_q_r <= {r_q_r[6:0], r_sum_r >= dsub};
            r_q_g <= {r_q_g[6:0], r_sum_g >= dsub};
            r_q_b <= {r_q_b[6:0], r_sum_b >= dsub};
        end
    end

    // Output register: hold the result until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_load) begin
            o_out_valid <= 1'b1;
        end else if (out_take) begin
            o_out_valid <= 1'b0;
        end
        if (out_load) begin
            o_red_mean   <= r_q_r;
            o_green_mean <= r_q_g;
            o_blue_mean  <= r_q_b;
            o_frame_end  <= r_last;
        end
    end

    // Checks
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVIDE) |-> (r_cnt != '0))
        else $error("window count is zero during divide");
    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_cur < STORE_AW'(STORE_DEPTH)))
        else $error("read address beyond history depth");
    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_addr < STORE_AW'(STORE_DEPTH))
        else $error("write address beyond history depth");
    a_out_behind_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_pos <= r_in_pos)
        else $error("output position ahead of input position");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready && r_state == ST_EMIT) |=> (r_state == ST_EMIT))
        else $error("result left emit while output register was full");

endmodule

`default_nettype wire

@@ tb/cbm_checker.sv @@
// Scoreboard for the clipped box mean filter: predicts every mean and checks the result channel.
`timescale 1ns / 100ps

module cbm_checker
    import cbm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire logic                  i_command,
    input  wire logic [7:0]            i_red_in,
    input  wire logic [7:0]            i_green_in,
    input  wire logic [7:0]            i_blue_in,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire logic [7:0]            i_red_mean,
    input  wire logic [7:0]            i_green_mean,
    input  wire logic [7:0]            i_blue_mean,
    input  wire logic                  i_frame_end,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked
);

    localparam int HIST_DEPTH = (2 * MAX_RADIUS + 1) * (MAX_WIDTH + 1);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } t_mean;

    logic [23:0]  pixel_hist [HIST_DEPTH];
    t_mean        mean_q [$];
    int unsigned  in_pos;
    int unsigned  out_pos;
    int unsigned  win_radius;
    int unsigned  row_len;
    int unsigned  row_count;
    int           fails;
    int           checked;

    function automatic int unsigned clamp_field(int unsigned v, int unsigned maxv);
        if (v == 0) begin
            return 1;
        end
        return (v > maxv) ? maxv : v;
    endfunction

    // Average the clipped window centered on raster position pos
    function automatic t_mean window_mean(int unsigned pos);
        int unsigned oy, ox, y0, y1, x0, x1, sr, sg, sb, cnt;
        logic [23:0] px;
        t_mean       m;
        oy = pos / row_len;
        ox = pos % row_len;
        y0 = (oy > win_radius) ? oy - win_radius : 0;
        y1 = (oy + win_radius < row_count - 1) ? oy + win_radius : row_count - 1;
        x0 = (ox > win_radius) ? ox - win_radius : 0;
        x1 = (ox + win_radius < row_len - 1) ? ox + win_radius : row_len - 1;
        sr = 0; sg = 0; sb = 0; cnt = 0;
        for (int unsigned y = y0; y <= y1; y++) begin
            for (int unsigned x = x0; x <= x1; x++) begin
                px = pixel_hist[(y * row_len + x) % HIST_DEPTH];
                sr += px[23:16];
                sg += px[15:8];
                sb += px[7:0];
                cnt++;
            end
        end
        m.red       = 8'(sr / cnt);
        m.green     = 8'(sg / cnt);
        m.blue      = 8'(sb / cnt);
        m.frame_end = (pos == row_len * row_count - 1);
        return m;
    endfunction

    // Append a prediction at the tail of the expected queue
    function automatic void enqueue_mean(t_mean m);
        mean_q.insert(mean_q.size(), m);
    endfunction

    initial begin
        for (int i = 0; i < HIST_DEPTH; i++) begin
            pixel_hist[i] = '0;
        end
    end

    always @(posedge i_clk) begin
        int unsigned total, lag;
        t_mean       exp_m;
        if (!i_rst_n) begin
            mean_q.delete();
            in_pos     = 0;
            out_pos    = 0;
            win_radius = 1;
            row_len    = 640;
            row_count  = 480;
            fails      = 0;
            checked    = 0;
        end else begin
            // Check a result transaction against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (mean_q.size() == 0) begin
                    $display("%0t: unexpected result r=%0d g=%0d b=%0d end=%0b", $time,
                             i_red_mean, i_green_mean, i_blue_mean, i_frame_end);
                    fails++;
                end else begin
                    exp_m = mean_q.pop_front();
                    checked++;
                    if (exp_m.red !== i_red_mean) begin
                        $display("%0t: red_mean expected %0d actual %0d", $time,
                                 exp_m.red, i_red_mean);
                        fails++;
                    end
                    if (exp_m.green !== i_green_mean) begin
                        $display("%0t: green_mean expected %0d actual %0d", $time,
                                 exp_m.green, i_green_mean);
                        fails++;
                    end
                    if (exp_m.blue !== i_blue_mean) begin
                        $display("%0t: blue_mean expected %0d actual %0d", $time,
                                 exp_m.blue, i_blue_mean);
                        fails++;
                    end
                    if (exp_m.frame_end !== i_frame_end) begin
                        $display("%0t: frame_end expected %0b actual %0b", $time,
                                 exp_m.frame_end, i_frame_end);
                        fails++;
                    end
                end
            end
            // Apply a register write; a radius, width or height write restarts the frame
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index inside {CFG_RADIUS, CFG_WIDTH, CFG_HEIGHT}) begin
                    case (i_cfg_index)
                        CFG_RADIUS: win_radius = clamp_field(32'(i_cfg_data[3:0]),
                                                             MAX_RADIUS);
                        CFG_WIDTH:  row_len    = clamp_field(32'(i_cfg_data[11:0]),
                                                             MAX_WIDTH);
                        CFG_HEIGHT: row_count  = clamp_field(32'(i_cfg_data[12:0]),
                                                             MAX_HEIGHT);
                        default: ;
                    endcase
                    in_pos  = 0;
                    out_pos = 0;
                end
            end
            // Advance the prediction on an input transaction
            if (i_in_valid && i_in_ready) begin
                total = row_len * row_count;
                lag   = win_radius * row_len + win_radius;
                if (i_command == CMD_PIXEL) begin
                    if (in_pos >= total) begin
                        in_pos  = 0;
                        out_pos = 0;
                    end
                    pixel_hist[in_pos % HIST_DEPTH] = {i_red_in, i_green_in, i_blue_in};
                    in_pos++;
                    if (in_pos - 1 >= lag && out_pos < total) begin
                        enqueue_mean(window_mean(out_pos));
                        out_pos++;
                    end
                end else if (in_pos >= total && out_pos < total) begin
                    enqueue_mean(window_mean(out_pos));
                    out_pos++;
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= mean_q.size();
        o_checked    <= checked;
    end

endmodule

@@ tb/clipped_box_mean_filter_rgb_tb.sv @@
// Testbench top for the clipped box mean filter: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module clipped_box_mean_filter_rgb_tb;
    import cbm_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_command;
    logic [7:0]            i_red_in;
    logic [7:0]            i_green_in;
    logic [7:0]            i_blue_in;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [7:0]            o_red_mean;
    logic [7:0]            o_green_mean;
    logic [7:0]            o_blue_mean;
    logic                  o_frame_end;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int          fail_count;
    int          pending;
    int          checked;
    int          idle_in;
    int          idle_out;
    int          hold_grants;
    int          items_sent;
    int          cfg_writes;
    int unsigned cur_radius;
    int unsigned cur_width;
    int unsigned cur_height;

    clipped_box_mean_filter_rgb i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_red_mean   (o_red_mean),
        .o_green_mean (o_green_mean),
        .o_blue_mean  (o_blue_mean),
        .o_frame_end  (o_frame_end),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    cbm_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_red_mean   (o_red_mean),
        .i_green_mean (o_green_mean),
        .i_blue_mean  (o_blue_mean),
        .i_frame_end  (o_frame_end),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bound the run
    initial begin
        #200_000_000;
        $display("tb: failure");
        $finish;
    end

    // Receiver: random back-pressure plus requested long hold-offs
    initial begin
        int seen_grants;
        int hold_left;
        seen_grants = 0;
        hold_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_grants != seen_grants) begin
                seen_grants = hold_grants;
                hold_left   = 700;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= idle_out);
            end
        end
    end

    function automatic int unsigned clamp_field(int unsigned v, int unsigned maxv);
        if (v == 0) begin
            return 1;
        end
        return (v > maxv) ? maxv : v;
    endfunction

    // Offer one transaction on the input channel, with random sender gaps
    task automatic send_item(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while ($urandom_range(99) < idle_in) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_red_in   <= r;
        i_green_in <= g;
        i_blue_in  <= b;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Write one register once the block has gone quiet
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        drain_results();
        repeat (400) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            CFG_RADIUS: cur_radius = clamp_field(32'(data[3:0]), MAX_RADIUS);
            CFG_WIDTH:  cur_width  = clamp_field(32'(data[11:0]), MAX_WIDTH);
            CFG_HEIGHT: cur_height = clamp_field(32'(data[12:0]), MAX_HEIGHT);
            default: ;
        endcase
    endtask

    task automatic set_frame(logic [CFG_DATA_W-1:0] r, logic [CFG_DATA_W-1:0] w,
                             logic [CFG_DATA_W-1:0] h);
        write_reg(CFG_RADIUS, r);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    // Send npix pixels (fill: 0 random, 1 all ones, 2 all zeros), with optional early
    // flushes mixed in, then nflush flush ticks
    task automatic send_frame(int npix, int nflush, int fill, int early_pct);
        logic [7:0] v;
        for (int i = 0; i < npix; i++) begin
            if (early_pct > 0 && $urandom_range(99) < early_pct) begin
                send_item(CMD_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
            end
            v = (fill == 1) ? 8'hff : 8'h00;
            if (fill == 0) begin
                send_item(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                send_item(CMD_PIXEL, v, v, v);
            end
        end
        for (int i = 0; i < nflush; i++) begin
            send_item(CMD_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        int total;
        int rnd_start;
        int drained;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_command   = CMD_PIXEL;
        i_red_in    = '0;
        i_green_in  = '0;
        i_blue_in   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        idle_in     = 22;
        idle_out    = 82;
        hold_grants = 0;
        items_sent  = 0;
        cfg_writes  = 0;
        cur_radius  = 1;
        cur_width   = 640;
        cur_height  = 480;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset geometry: a few pixels, far short of the first result
        send_frame(5, 2, 0, 0);
        // Small frame of full-scale pixels, with flushes before it completes
        set_frame(13'd1, 13'd4, 13'd3);
        send_frame(12, 0, 1, 20);
        send_frame(0, 6, 0, 0);
        // Zero registers clamp to one: a single-pixel frame, extra flushes give nothing
        set_frame(13'd0, 13'd0, 13'd0);
        send_frame(1, 3, 0, 0);
        // Oversized radius clamps to the maximum; window always clipped
        set_frame(13'd15, 13'd5, 13'd4);
        send_frame(20, 22, 2, 0);
        // Pixel after a complete frame restarts it, dropping undrained outputs
        send_frame(20, 0, 0, 0);
        send_frame(20, 20, 0, 0);
        // Widest row, single line, partly sent: flushes come too early
        set_frame(13'd8, 13'd4095, 13'd1);
        send_frame(60, 4, 0, 0);
        // Tallest frame, one pixel wide, partly sent
        set_frame(13'd8, 13'd2048, 13'd8191);
        write_reg(CFG_WIDTH, 13'h1000);
        send_frame(30, 0, 0, 0);
        // Unused register index writes nothing
        set_frame(13'd2, 13'd6, 13'd5);
        write_reg(CFG_SPARE, 13'h1fff);
        send_frame(30, 30, 0, 0);

        // Random geometry and content
        rnd_start = items_sent;
        while (items_sent - rnd_start < 1140) begin
            if (items_sent - rnd_start > 760) begin
                idle_in  = 0;
                idle_out = 0;
            end else if (items_sent - rnd_start > 380) begin
                idle_in  = 82;
                idle_out = 22;
            end
            if ($urandom_range(9) == 0) begin
                set_frame(13'($urandom), 13'($urandom), 13'($urandom_range(1, 12)));
                if (cur_width * cur_height > 200) begin
                    write_reg(CFG_WIDTH, 13'($urandom_range(1, 16)));
                end
            end else begin
                set_frame(13'($urandom_range(1, 3)), 13'($urandom_range(1, 16)),
                          13'($urandom_range(1, 12)));
            end
            total = cur_width * cur_height;
            drained = ($urandom_range(5) == 0) ? $urandom_range(total) : total;
            if ($urandom_range(3) == 0) begin
                // Stall the receiver long enough to back up the input
                hold_grants++;
            end
            send_frame(total, 0, 0, $urandom_range(3) == 0 ? 5 : 0);
            if ($urandom_range(4) == 0) begin
                // Pause the sender until every result so far has come
                drain_results();
            end
            send_frame(0, drained + $urandom_range(2), 0, 0);
        end

        drain_results();
        repeat (400) @(posedge i_clk);
        $display("tb: %0d input transactions, %0d register writes", items_sent, cfg_writes);
        $display("tb: %0d means checked over clipped edges, restarts and flushes", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ clipped_box_mean_filter_rgb.f @@
rtl/core/cbm_pkg.sv
rtl/core/cbm_ram.sv
rtl/core/clipped_box_mean_filter_rgb.sv
tb/cbm_checker.sv
tb/clipped_box_mean_filter_rgb_tb.sv
